[src/ssb_pkg.sv]
// ----------------------------------------------------------------------------
// ssb_pkg: shared definitions for the sprite sheet blitter
// Field widths, bus command codes, register indexes, header step codes and
// the command and status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package ssb_pkg;

   // sizing
   localparam int SHEET_BYTES    = 32768;
   localparam int MAX_SPRITE_DIM = 256;
   localparam int ADDR_W         = $clog2(SHEET_BYTES);
   localparam int PIX_W          = ADDR_W - 1;
   localparam int DIM_W          = $clog2(MAX_SPRITE_DIM + 1);
   localparam int COL_W          = $clog2(MAX_SPRITE_DIM);
   localparam int ROW_W          = $clog2(2 * MAX_SPRITE_DIM);

   // field widths
   localparam int OPCODE_W    = 2;
   localparam int LOAD_ADDR_W = 15;
   localparam int BYTE_W      = 8;
   localparam int POS_W       = 16;
   localparam int FRAME_W     = 8;
   localparam int OFFSET_W    = 8;
   localparam int CFG_DIM_W   = 9;
   localparam int COLOR_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int HDR_W       = 4;
   localparam int PHASE_W     = 2;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DRAW = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SPRITE_WIDTH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPRITE_HEIGHT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHEET_FRAMES     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIRROR           = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZOOM_DOUBLE      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND_COLOR = 3'd5;

   // register reset values
   localparam logic [CFG_DIM_W-1:0] SPRITE_WIDTH_RST  = 9'd16;
   localparam logic [CFG_DIM_W-1:0] SPRITE_HEIGHT_RST = 9'd16;
   localparam logic [CFG_DIM_W-1:0] SHEET_FRAMES_RST  = 9'd1;

   // header steps
   localparam logic [HDR_W-1:0] HDR_MEMWR_FIRST = 4'd0;
   localparam logic [HDR_W-1:0] HDR_COLUMN      = 4'd1;
   localparam logic [HDR_W-1:0] HDR_X1_HI       = 4'd2;
   localparam logic [HDR_W-1:0] HDR_X1_LO       = 4'd3;
   localparam logic [HDR_W-1:0] HDR_X2_HI       = 4'd4;
   localparam logic [HDR_W-1:0] HDR_X2_LO       = 4'd5;
   localparam logic [HDR_W-1:0] HDR_PAGE        = 4'd6;
   localparam logic [HDR_W-1:0] HDR_Y1_HI       = 4'd7;
   localparam logic [HDR_W-1:0] HDR_Y1_LO       = 4'd8;
   localparam logic [HDR_W-1:0] HDR_Y2_HI       = 4'd9;
   localparam logic [HDR_W-1:0] HDR_Y2_LO       = 4'd10;
   localparam logic [HDR_W-1:0] HDR_MEMWR_LAST  = 4'd11;
   localparam logic [HDR_W-1:0] HEADER_LEN      = 4'd12;

   // lcd bus commands and transparent keys
   localparam logic [BYTE_W-1:0] CMD_COLUMN_ADDR  = 8'h2a;
   localparam logic [BYTE_W-1:0] CMD_PAGE_ADDR    = 8'h2b;
   localparam logic [BYTE_W-1:0] CMD_MEMORY_WRITE = 8'h2c;
   localparam logic [BYTE_W-1:0] KEY_COLOR_A      = 8'h3a;
   localparam logic [BYTE_W-1:0] KEY_COLOR_B      = 8'he5;

   typedef struct packed {
      logic load_we;
      logic draw_start;
      logic mul_en;
      logic addr_en;
      logic rd_hi;
      logic rd_lo;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic drawing;
      logic in_header;
      logic phase_zero;
      logic out_free;
   } dp_status_type;

   // zero counts as one, oversize as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_SPRITE_DIM) begin
         r = DIM_W'(MAX_SPRITE_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage

[src/ssb_ram.sv]
// ----------------------------------------------------------------------------
// ssb_ram: generic single-port ram
// One write and one read per cycle on the shared address, read data registered and held between reads.
// ----------------------------------------------------------------------------
module ssb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/ssb_ctrl.sv]
// ----------------------------------------------------------------------------
// ssb_ctrl: sequencing state machine
// Takes one beat at a time; a tick steps the datapath through address multiply and
// forming (first pixel byte only), two sheet reads (pixel bytes) and the output load.
// ----------------------------------------------------------------------------
module ssb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ssb_pkg::OPCODE_W-1:0]  req_opcode,
   input  ssb_pkg::dp_status_type        status,
   output ssb_pkg::ctrl_cmd_type         cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_ADDR  = 6'b000100,
      ST_RD_HI = 6'b001000,
      ST_RD_LO = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_opcode)
                  ssb_pkg::OP_LOAD: begin
                     cmd.load_we = 1'b1;
                  end
                  ssb_pkg::OP_DRAW: begin
                     cmd.draw_start = !status.drawing;
                  end
                  ssb_pkg::OP_TICK: begin
                     if (status.drawing) begin
                        if (status.in_header) begin
                           state_in = ST_EMIT;
                        end else if (status.phase_zero) begin
                           state_in = ST_MUL;
                        end else begin
                           state_in = ST_RD_HI;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.addr_en = 1'b1;
            state_in    = ST_RD_HI;
         end
         ST_RD_HI: begin
            cmd.rd_hi = 1'b1;
            state_in  = ST_RD_LO;
         end
         ST_RD_LO: begin
            cmd.rd_lo = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/ssb_dp.sv]
// ----------------------------------------------------------------------------
// ssb_dp: blitter datapath
// Config registers, draw counters, pixel address arithmetic, sheet ram and the
// output register.
// ----------------------------------------------------------------------------
module ssb_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ssb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ssb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [ssb_pkg::LOAD_ADDR_W-1:0] req_load_address,
   input  logic [ssb_pkg::BYTE_W-1:0]      req_load_byte,
   input  logic [ssb_pkg::POS_W-1:0]       req_pos_x,
   input  logic [ssb_pkg::POS_W-1:0]       req_pos_y,
   input  logic [ssb_pkg::FRAME_W-1:0]     req_frame_index,
   input  logic [ssb_pkg::OFFSET_W-1:0]    req_pixel_offset,
   input  ssb_pkg::ctrl_cmd_type           cmd,
   output ssb_pkg::dp_status_type          status,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [ssb_pkg::BYTE_W-1:0]      rsp_bus_byte,
   output logic                            rsp_is_data,
   output logic                            rsp_last_of_draw
);

   localparam logic [ssb_pkg::PIX_W-1:0]  PIX_ONE  = ssb_pkg::PIX_W'(1);
   localparam logic [ssb_pkg::ADDR_W-1:0] ADDR_ONE = ssb_pkg::ADDR_W'(1);

   // config registers
   logic [ssb_pkg::CFG_DIM_W-1:0] width_ff, width_in;
   logic [ssb_pkg::CFG_DIM_W-1:0] height_ff, height_in;
   logic [ssb_pkg::CFG_DIM_W-1:0] frames_ff, frames_in;
   logic                          mirror_ff, mirror_in;
   logic                          zoom_ff, zoom_in;
   logic [ssb_pkg::COLOR_W-1:0]   bg_ff, bg_in;

   // draw control state
   logic                          drawing_ff, drawing_in;
   logic [ssb_pkg::HDR_W-1:0]     header_step_ff, header_step_in;
   logic [ssb_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [ssb_pkg::COL_W-1:0]     col_ff, col_in;
   logic [ssb_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // payload
   logic [ssb_pkg::POS_W-1:0]     x_ff, y_ff;
   logic [ssb_pkg::FRAME_W-1:0]   frame_ff;
   logic [ssb_pkg::OFFSET_W-1:0]  offset_ff;
   logic [ssb_pkg::PIX_W-1:0]     prod_row_ff, prod_frame_ff;
   logic [ssb_pkg::ADDR_W-1:0]    ptr_ff;
   logic [ssb_pkg::BYTE_W-1:0]    hi_ff;
   logic [ssb_pkg::BYTE_W-1:0]    rsp_byte_ff, rsp_byte_in;
   logic                          rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [ssb_pkg::DIM_W-1:0]     w_clamp, h_clamp;
   logic [ssb_pkg::DIM_W:0]       span_x, span_y, rows_lim;
   logic [ssb_pkg::POS_W-1:0]     x2, y2;
   logic [ssb_pkg::ROW_W-1:0]     row_src;
   logic [ssb_pkg::PIX_W-1:0]     prod_row_in, prod_frame_in, base, off, pix;
   logic [ssb_pkg::ADDR_W-1:0]    ram_addr;
   logic [ssb_pkg::BYTE_W-1:0]    ram_rdata;
   logic [ssb_pkg::BYTE_W-1:0]    hdr_byte, pix_byte;
   logic                          hdr_is_data, in_header, key, final_byte;
   logic [ssb_pkg::COL_W:0]       col_inc;
   logic [ssb_pkg::ROW_W:0]       row_inc;
   logic                          col_end, row_end;

   // geometry
   assign w_clamp  = ssb_pkg::clamp_dim(width_ff);
   assign h_clamp  = ssb_pkg::clamp_dim(height_ff);
   assign span_x   = zoom_ff ? {w_clamp, 1'b0} : {1'b0, w_clamp};
   assign span_y   = zoom_ff ? {h_clamp, 1'b0} : {1'b0, h_clamp};
   assign rows_lim = span_y;
   assign x2 = x_ff + ssb_pkg::POS_W'(span_x) - ssb_pkg::POS_W'(1);
   assign y2 = y_ff + ssb_pkg::POS_W'(span_y) - ssb_pkg::POS_W'(1);

   // pixel address, kept in pixel units modulo the sheet
   assign row_src       = zoom_ff ? (row_ff >> 1) : row_ff;
   assign prod_row_in   = ssb_pkg::PIX_W'(ssb_pkg::PIX_W'(row_src)
                                          * ssb_pkg::PIX_W'(w_clamp));
   assign prod_frame_in = ssb_pkg::PIX_W'(ssb_pkg::PIX_W'(frame_ff)
                                          * ssb_pkg::PIX_W'(w_clamp));
   assign base = ssb_pkg::PIX_W'(prod_row_ff * ssb_pkg::PIX_W'(frames_ff)) + prod_frame_ff;
   assign off  = zoom_ff ? '0 : ssb_pkg::PIX_W'(offset_ff);
   assign pix  = mirror_ff
               ? base - PIX_ONE - off + ssb_pkg::PIX_W'(w_clamp) - ssb_pkg::PIX_W'(col_ff)
               : base + PIX_ONE + off + ssb_pkg::PIX_W'(col_ff);

   // sheet memory: loads in idle, two reads per pixel beat
   assign ram_addr = cmd.load_we ? ssb_pkg::ADDR_W'(req_load_address)
                   : (cmd.rd_lo ? ptr_ff + ADDR_ONE : ptr_ff);

   ssb_ram #(
      .WIDTH (ssb_pkg::BYTE_W),
      .DEPTH (ssb_pkg::SHEET_BYTES)
   ) u_sheet_ram (
      .clock (clock),
      .we    (cmd.load_we),
      .re    (cmd.rd_hi | cmd.rd_lo),
      .addr  (ram_addr),
      .wdata (req_load_byte),
      .rdata (ram_rdata)
   );

   // window header
   assign in_header = header_step_ff < ssb_pkg::HEADER_LEN;

   always_comb begin
      hdr_is_data = 1'b1;
      hdr_byte    = ssb_pkg::CMD_MEMORY_WRITE;
      case (header_step_ff)
         ssb_pkg::HDR_MEMWR_FIRST: begin
            hdr_is_data = 1'b0;
            hdr_byte    = ssb_pkg::CMD_MEMORY_WRITE;
         end
         ssb_pkg::HDR_COLUMN: begin
            hdr_is_data = 1'b0;
            hdr_byte    = ssb_pkg::CMD_COLUMN_ADDR;
         end
         ssb_pkg::HDR_X1_HI: hdr_byte = x_ff[15:8];
         ssb_pkg::HDR_X1_LO: hdr_byte = x_ff[7:0];
         ssb_pkg::HDR_X2_HI: hdr_byte = x2[15:8];
         ssb_pkg::HDR_X2_LO: hdr_byte = x2[7:0];
         ssb_pkg::HDR_PAGE: begin
            hdr_is_data = 1'b0;
            hdr_byte    = ssb_pkg::CMD_PAGE_ADDR;
         end
         ssb_pkg::HDR_Y1_HI: hdr_byte = y_ff[15:8];
         ssb_pkg::HDR_Y1_LO: hdr_byte = y_ff[7:0];
         ssb_pkg::HDR_Y2_HI: hdr_byte = y2[15:8];
         ssb_pkg::HDR_Y2_LO: hdr_byte = y2[7:0];
         ssb_pkg::HDR_MEMWR_LAST: begin
            hdr_is_data = 1'b0;
            hdr_byte    = ssb_pkg::CMD_MEMORY_WRITE;
         end
         default: begin
            hdr_is_data = 1'b0;
            hdr_byte    = ssb_pkg::CMD_MEMORY_WRITE;
         end
      endcase
   end

   // pixel byte select; ram_rdata holds the low byte here
   assign key = (hi_ff == ssb_pkg::KEY_COLOR_A) || (hi_ff == ssb_pkg::KEY_COLOR_B);

   always_comb begin
      if (zoom_ff) begin
         if (key) begin
            pix_byte = phase_ff[0] ? bg_ff[7:0] : bg_ff[15:8];
         end else begin
            pix_byte = phase_ff[0] ? ram_rdata : hi_ff;
         end
         final_byte = (phase_ff == 2'd3);
      end else begin
         pix_byte   = (phase_ff == '0) ? hi_ff : ram_rdata;
         final_byte = (phase_ff != '0);
      end
   end

   assign col_inc = {1'b0, col_ff} + (ssb_pkg::COL_W + 1)'(1);
   assign row_inc = {1'b0, row_ff} + (ssb_pkg::ROW_W + 1)'(1);
   assign col_end = col_inc >= w_clamp;
   assign row_end = row_inc >= rows_lim;

   // next state
   always_comb begin
      width_in       = width_ff;
      height_in      = height_ff;
      frames_in      = frames_ff;
      mirror_in      = mirror_ff;
      zoom_in        = zoom_ff;
      bg_in          = bg_ff;
      drawing_in     = drawing_ff;
      header_step_in = header_step_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      phase_in       = phase_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_we) begin
         case (csr_index)
            ssb_pkg::CSR_SPRITE_WIDTH:     width_in  = csr_wdata[ssb_pkg::CFG_DIM_W-1:0];
            ssb_pkg::CSR_SPRITE_HEIGHT:    height_in = csr_wdata[ssb_pkg::CFG_DIM_W-1:0];
            ssb_pkg::CSR_SHEET_FRAMES:     frames_in = csr_wdata[ssb_pkg::CFG_DIM_W-1:0];
            ssb_pkg::CSR_MIRROR:           mirror_in = csr_wdata[0];
            ssb_pkg::CSR_ZOOM_DOUBLE:      zoom_in   = csr_wdata[0];
            ssb_pkg::CSR_BACKGROUND_COLOR: bg_in     = csr_wdata;
            default: begin
            end
         endcase
      end

      if (cmd.draw_start) begin
         drawing_in     = 1'b1;
         header_step_in = '0;
         row_in         = '0;
         col_in         = '0;
         phase_in       = '0;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (in_header) begin
            rsp_byte_in    = hdr_byte;
            rsp_data_in    = hdr_is_data;
            rsp_last_in    = 1'b0;
            header_step_in = header_step_ff + ssb_pkg::HDR_W'(1);
         end else begin
            rsp_byte_in = pix_byte;
            rsp_data_in = 1'b1;
            rsp_last_in = final_byte & col_end & row_end;
            if (final_byte) begin
               phase_in = '0;
               if (col_end) begin
                  col_in = '0;
                  if (row_end) begin
                     drawing_in     = 1'b0;
                     row_in         = '0;
                     header_step_in = '0;
                  end else begin
                     row_in = row_inc[ssb_pkg::ROW_W-1:0];
                  end
               end else begin
                  col_in = col_inc[ssb_pkg::COL_W-1:0];
               end
            end else begin
               phase_in = phase_ff + ssb_pkg::PHASE_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= ssb_pkg::SPRITE_WIDTH_RST;
         height_ff      <= ssb_pkg::SPRITE_HEIGHT_RST;
         frames_ff      <= ssb_pkg::SHEET_FRAMES_RST;
         mirror_ff      <= 1'b0;
         zoom_ff        <= 1'b0;
         bg_ff          <= '0;
         drawing_ff     <= 1'b0;
         header_step_ff <= '0;
         row_ff         <= '0;
         col_ff         <= '0;
         phase_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         frames_ff      <= frames_in;
         mirror_ff      <= mirror_in;
         zoom_ff        <= zoom_in;
         bg_ff          <= bg_in;
         drawing_ff     <= drawing_in;
         header_step_ff <= header_step_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.draw_start) begin
         x_ff      <= req_pos_x;
         y_ff      <= req_pos_y;
         frame_ff  <= req_frame_index;
         offset_ff <= req_pixel_offset;
      end
      if (cmd.mul_en) begin
         prod_row_ff   <= prod_row_in;
         prod_frame_ff <= prod_frame_in;
      end
      if (cmd.addr_en) begin
         ptr_ff <= {pix, 1'b0};
      end
      if (cmd.rd_lo) begin
         hi_ff <= ram_rdata;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.drawing    = drawing_ff;
   assign status.in_header  = in_header;
   assign status.phase_zero = (phase_ff == '0);
   assign status.out_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bus_byte     = rsp_byte_ff;
   assign rsp_is_data      = rsp_data_ff;
   assign rsp_last_of_draw = rsp_last_ff;

endmodule

[src/sprite_sheet_blitter.sv]
// ----------------------------------------------------------------------------
// sprite_sheet_blitter: RGB565 sprite blitter for an 8-bit LCD bus
// Loads a sprite sheet byte by byte and streams a draw as LCD command and
// data bytes, one result beat per tick beat during a draw.
// ----------------------------------------------------------------------------
// Each req beat carries an opcode: load stores one sheet byte, draw latches
// position, frame and offset (ignored while a draw is running), tick asks for
// the next bus byte of the running draw and is the only beat that yields a
// rsp beat. A draw sends the memory-write command, the column and page window
// commands with their four bytes each, memory-write again, then two bytes per
// pixel (four in zoom mode, where rows are also sent twice). Beats are taken
// one at a time: a load, a draw, a tick outside a draw or an unused opcode is
// done in idle, a header tick goes straight to emit, the first pixel byte steps
// through multiply, address, both reads and emit, other pixel bytes skip
// multiply and address. The single sheet ram port is read twice per pixel byte
// (high byte for the transparent key, then low byte), and the address is
// formed in two registered multiply steps. A finished beat waits in the rsp
// register while the next req beat is taken. The sheet ram has no reset and
// needs no clearing pass; bytes never loaded read back as unknown.
// Registers: 0 sprite width, 1 sprite height, 2 frames per sheet row,
// 3 mirror, 4 zoom, 5 background color; write them only between beats.
// ----------------------------------------------------------------------------
module sprite_sheet_blitter (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_we,
   input  logic [ssb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ssb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ssb_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [ssb_pkg::LOAD_ADDR_W-1:0] req_load_address,
   input  logic [ssb_pkg::BYTE_W-1:0]      req_load_byte,
   input  logic [ssb_pkg::POS_W-1:0]       req_pos_x,
   input  logic [ssb_pkg::POS_W-1:0]       req_pos_y,
   input  logic [ssb_pkg::FRAME_W-1:0]     req_frame_index,
   input  logic [ssb_pkg::OFFSET_W-1:0]    req_pixel_offset,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ssb_pkg::BYTE_W-1:0]      rsp_bus_byte,
   output logic                            rsp_is_data,
   output logic                            rsp_last_of_draw
);

   ssb_pkg::ctrl_cmd_type  cmd;
   ssb_pkg::dp_status_type status;

   // sequencer: one beat at a time
   ssb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd)
   );

   // counters, address math, sheet ram and rsp register
   ssb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_load_address (req_load_address),
      .req_load_byte    (req_load_byte),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_frame_index  (req_frame_index),
      .req_pixel_offset (req_pixel_offset),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_bus_byte     (rsp_bus_byte),
      .rsp_is_data      (rsp_is_data),
      .rsp_last_of_draw (rsp_last_of_draw)
   );

`ifndef SYNTHESIS
   // a beat is only loaded into a free rsp register
   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("rsp beat loaded over a pending beat");

   // bus bytes come only from a running draw
   a_emit_while_drawing: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.drawing)
      else $error("rsp beat produced outside a draw");

   // a draw beat while busy must not restart the draw
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.draw_start |-> !status.drawing)
      else $error("draw restarted while busy");

   // ram is never written while a pixel read is in flight
   a_no_load_during_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_hi || cmd.rd_lo || cmd.mul_en || cmd.addr_en) |-> !req_ready)
      else $error("request taken during a pixel read");
`endif

endmodule
